// File: design/rti_pkg.sv
// Package: widths, coordinate vector types and pipeline payload structs for the ray/triangle test.
package rti_pkg;

  localparam int CoordBits = 16;
  localparam int InW       = 3 * CoordBits;
  localparam int DifW      = CoordBits + 1;
  localparam int HW        = 2 * CoordBits + 2;
  localparam int QW        = 2 * CoordBits + 3;
  localparam int FW        = 3 * CoordBits + 6;
  localparam int CfgW      = 32;
  localparam int LoW       = FW / 2;
  localparam int HiW       = FW - LoW;
  localparam int DistFrac  = 16;
  localparam int ProdW     = FW + CfgW;
  localparam int AddrW     = 3;
  localparam int Latency   = 8;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_MIN_DIST  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] z;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } crd_t;

  typedef struct packed {
    logic signed [DifW-1:0] z;
    logic signed [DifW-1:0] y;
    logic signed [DifW-1:0] x;
  } dif_t;

  typedef struct packed {
    logic signed [HW-1:0] z;
    logic signed [HW-1:0] y;
    logic signed [HW-1:0] x;
  } hv_t;

  typedef struct packed {
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] x;
  } qv_t;

  typedef struct packed {
    crd_t dir;
    dif_t e1;
    dif_t e2;
    dif_t s;
    hv_t  h;
    qv_t  q;
  } geo_t;

  typedef struct packed {
    logic signed [FW-1:0] det;
    logic signed [FW-1:0] nu;
    logic signed [FW-1:0] nv;
    logic signed [FW-1:0] nt;
  } dot_t;

  typedef struct packed {
    logic [CfgW-1:0] thr;
    logic [CfgW-1:0] min_dist;
  } cfg_t;

  function automatic dif_t vsub(crd_t a, crd_t b);
    dif_t r;
    r.x = DifW'(a.x) - DifW'(b.x);
    r.y = DifW'(a.y) - DifW'(b.y);
    r.z = DifW'(a.z) - DifW'(b.z);
    return r;
  endfunction

endpackage

// File: design/rti_cfg.sv
// Configuration registers behind the APB-style port.
module rti_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rti_pkg::AddrW-1:0] paddr,
  input  logic [rti_pkg::CfgW-1:0]  pwdata,
  output logic [rti_pkg::CfgW-1:0]  prdata,
  output logic                      pready,
  output rti_pkg::cfg_t             cfg_o
);
  import rti_pkg::*;

  logic [CfgW-1:0] thr_q, thr_d;
  logic [CfgW-1:0] md_q, md_d;
  logic            wr_en;
  reg_idx_e        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    thr_d = thr_q;
    md_d  = md_q;
    if (wr_en) begin
      case (idx)
        REG_THRESHOLD: thr_d = pwdata;
        REG_MIN_DIST:  md_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= CfgW'(17);
      md_q  <= CfgW'(1);
    end else begin
      thr_q <= thr_d;
      md_q  <= md_d;
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = thr_q;
      REG_MIN_DIST:  prdata = md_q;
      default:       prdata = thr_q;
    endcase
  end

  assign cfg_o.thr      = thr_q;
  assign cfg_o.min_dist = md_q;

endmodule

// File: design/rti_geom.sv
// Stages 1-3: edge vectors, then h = dir x e2 and q = s x e1.
module rti_geom (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic [rti_pkg::InW-1:0] ray_origin_i,
  input  logic [rti_pkg::InW-1:0] ray_direction_i,
  input  logic [rti_pkg::InW-1:0] vertex_a_i,
  input  logic [rti_pkg::InW-1:0] vertex_b_i,
  input  logic [rti_pkg::InW-1:0] vertex_c_i,
  output logic                    vld_o,
  output rti_pkg::geo_t           geo_o
);
  import rti_pkg::*;

  logic v1_q, v2_q, v3_q;
  crd_t dir1_q, dir2_q;
  dif_t e11_q, e21_q, s1_q;
  dif_t e12_q, e22_q, s2_q;
  logic signed [HW-1:0] hp_q [6];
  logic signed [QW-1:0] qp_q [6];
  geo_t geo_q;
  crd_t va, vb, vc, org;

  assign org = crd_t'(ray_origin_i);
  assign va  = crd_t'(vertex_a_i);
  assign vb  = crd_t'(vertex_b_i);
  assign vc  = crd_t'(vertex_c_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dir1_q <= crd_t'(ray_direction_i);
    e11_q  <= vsub(vb, va);
    e21_q  <= vsub(vc, va);
    s1_q   <= vsub(org, va);

    dir2_q <= dir1_q;
    e12_q  <= e11_q;
    e22_q  <= e21_q;
    s2_q   <= s1_q;
    hp_q[0] <= HW'(dir1_q.y) * HW'(e21_q.z);
    hp_q[1] <= HW'(dir1_q.z) * HW'(e21_q.y);
    hp_q[2] <= HW'(dir1_q.z) * HW'(e21_q.x);
    hp_q[3] <= HW'(dir1_q.x) * HW'(e21_q.z);
    hp_q[4] <= HW'(dir1_q.x) * HW'(e21_q.y);
    hp_q[5] <= HW'(dir1_q.y) * HW'(e21_q.x);
    qp_q[0] <= QW'(s1_q.y) * QW'(e11_q.z);
    qp_q[1] <= QW'(s1_q.z) * QW'(e11_q.y);
    qp_q[2] <= QW'(s1_q.z) * QW'(e11_q.x);
    qp_q[3] <= QW'(s1_q.x) * QW'(e11_q.z);
    qp_q[4] <= QW'(s1_q.x) * QW'(e11_q.y);
    qp_q[5] <= QW'(s1_q.y) * QW'(e11_q.x);

    geo_q.dir <= dir2_q;
    geo_q.e1  <= e12_q;
    geo_q.e2  <= e22_q;
    geo_q.s   <= s2_q;
    geo_q.h.x <= hp_q[0] - hp_q[1];
    geo_q.h.y <= hp_q[2] - hp_q[3];
    geo_q.h.z <= hp_q[4] - hp_q[5];
    geo_q.q.x <= qp_q[0] - qp_q[1];
    geo_q.q.y <= qp_q[2] - qp_q[3];
    geo_q.q.z <= qp_q[4] - qp_q[5];
  end

  assign vld_o = v3_q;
  assign geo_o = geo_q;

endmodule

// File: design/rti_dot.sv
// Stages 4-5: the four dot products det, nu, nv and nt.
module rti_dot (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  rti_pkg::geo_t geo_i,
  output logic          vld_o,
  output rti_pkg::dot_t dot_o
);
  import rti_pkg::*;

  logic v4_q, v5_q;
  logic signed [FW-1:0] pd_q [3];
  logic signed [FW-1:0] pu_q [3];
  logic signed [FW-1:0] pv_q [3];
  logic signed [FW-1:0] pt_q [3];
  dot_t dot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= vld_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pd_q[0] <= FW'(geo_i.e1.x) * FW'(geo_i.h.x);
    pd_q[1] <= FW'(geo_i.e1.y) * FW'(geo_i.h.y);
    pd_q[2] <= FW'(geo_i.e1.z) * FW'(geo_i.h.z);
    pu_q[0] <= FW'(geo_i.s.x) * FW'(geo_i.h.x);
    pu_q[1] <= FW'(geo_i.s.y) * FW'(geo_i.h.y);
    pu_q[2] <= FW'(geo_i.s.z) * FW'(geo_i.h.z);
    pv_q[0] <= FW'(geo_i.dir.x) * FW'(geo_i.q.x);
    pv_q[1] <= FW'(geo_i.dir.y) * FW'(geo_i.q.y);
    pv_q[2] <= FW'(geo_i.dir.z) * FW'(geo_i.q.z);
    pt_q[0] <= FW'(geo_i.e2.x) * FW'(geo_i.q.x);
    pt_q[1] <= FW'(geo_i.e2.y) * FW'(geo_i.q.y);
    pt_q[2] <= FW'(geo_i.e2.z) * FW'(geo_i.q.z);

    dot_q.det <= pd_q[0] + pd_q[1] + pd_q[2];
    dot_q.nu  <= pu_q[0] + pu_q[1] + pu_q[2];
    dot_q.nv  <= pv_q[0] + pv_q[1] + pv_q[2];
    dot_q.nt  <= pt_q[0] + pt_q[1] + pt_q[2];
  end

  assign vld_o = v5_q;
  assign dot_o = dot_q;

endmodule

// File: design/rti_decide.sv
// Stages 6-8: sign fold, range checks and the distance compare against |det| * min_distance.
module rti_decide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  rti_pkg::dot_t dot_i,
  input  rti_pkg::cfg_t cfg_i,
  output logic          vld_o,
  output logic          hit_o
);
  import rti_pkg::*;

  logic v6_q, v7_q, v8_q;
  logic signed [FW:0] fdet_q, fnu_q, fnv_q, fnt_q;
  logic signed [FW:0] det_w, nu_w, nv_w, nt_w;
  logic               neg;
  logic [FW-1:0]      adet;
  logic signed [FW+1:0] sum_uv;
  logic               det_ok, u_ok, v_ok;
  logic               ok_q;
  logic               ntpos_q;
  logic [FW-1:0]      ntm_q;
  logic [LoW+CfgW-1:0] plo_q;
  logic [HiW+CfgW-1:0] phi_q;
  logic [ProdW-1:0]   prod, rhs;
  logic               hit_q;

  assign det_w = (FW+1)'(dot_i.det);
  assign nu_w  = (FW+1)'(dot_i.nu);
  assign nv_w  = (FW+1)'(dot_i.nv);
  assign nt_w  = (FW+1)'(dot_i.nt);
  assign neg   = dot_i.det[FW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v6_q  <= vld_i;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      hit_q <= v7_q && ok_q && ntpos_q && (prod < rhs);
    end
  end

  // stage 7 checks
  assign adet   = fdet_q[FW-1:0];
  assign sum_uv = (FW+2)'(fnu_q) + (FW+2)'(fnv_q);
  assign det_ok = (adet != '0) && (adet >= FW'(cfg_i.thr));
  assign u_ok   = !fnu_q[FW] && (fnu_q <= fdet_q);
  assign v_ok   = !fnv_q[FW] && (sum_uv <= (FW+2)'(fdet_q));

  // stage 8 compare
  assign prod = (ProdW'(phi_q) << LoW) + ProdW'(plo_q);
  assign rhs  = ProdW'({ntm_q, DistFrac'(0)});

  always_ff @(posedge clk_i) begin
    fdet_q <= neg ? -det_w : det_w;
    fnu_q  <= neg ? -nu_w  : nu_w;
    fnv_q  <= neg ? -nv_w  : nv_w;
    fnt_q  <= neg ? -nt_w  : nt_w;

    ok_q    <= det_ok && u_ok && v_ok;
    ntpos_q <= !fnt_q[FW] && (fnt_q != '0);
    ntm_q   <= fnt_q[FW-1:0];
    plo_q   <= (LoW+CfgW)'(adet[LoW-1:0]) * (LoW+CfgW)'(cfg_i.min_dist);
    phi_q   <= (HiW+CfgW)'(adet[FW-1:LoW]) * (HiW+CfgW)'(cfg_i.min_dist);
  end

  assign vld_o = v8_q;
  assign hit_o = hit_q;

endmodule

// File: design/ray_triangle_intersect_test_core.sv
// Top level of the pipelined Moller-Trumbore ray/triangle hit test.
//
//  channel   signals                                      direction  handshake
//  request   start, busy, ray_origin_i .. vertex_c_i      in         start && !busy
//  result    done_o, hit_o                                out        done_o strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata, prdata in/out     APB, pready tied high
//
//  One request per cycle; busy is never raised.
//  The pipeline has 3 stages for edges and cross products, 2 for dot
//  products, 3 for sign fold, range checks and the split distance product.
//  Reset clears the valid bits of every stage and loads the register defaults.
//  The result strobe cannot be held off, so the pipeline never stalls.
module ray_triangle_intersect_test_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [rti_pkg::InW-1:0]   ray_origin_i,
  input  logic [rti_pkg::InW-1:0]   ray_direction_i,
  input  logic [rti_pkg::InW-1:0]   vertex_a_i,
  input  logic [rti_pkg::InW-1:0]   vertex_b_i,
  input  logic [rti_pkg::InW-1:0]   vertex_c_i,
  output logic                      done_o,
  output logic                      hit_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rti_pkg::AddrW-1:0] paddr,
  input  logic [rti_pkg::CfgW-1:0]  pwdata,
  output logic [rti_pkg::CfgW-1:0]  prdata,
  output logic                      pready
);
  import rti_pkg::*;

  cfg_t cfg;
  geo_t geo;
  dot_t dot;
  logic geo_vld, dot_vld;

  assign busy = 1'b0;

  rti_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rti_geom u_geom (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vld_i           (start && !busy),
    .ray_origin_i    (ray_origin_i),
    .ray_direction_i (ray_direction_i),
    .vertex_a_i      (vertex_a_i),
    .vertex_b_i      (vertex_b_i),
    .vertex_c_i      (vertex_c_i),
    .vld_o           (geo_vld),
    .geo_o           (geo)
  );

  rti_dot u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (geo_vld),
    .geo_i  (geo),
    .vld_o  (dot_vld),
    .dot_o  (dot)
  );

  rti_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (dot_vld),
    .dot_i  (dot),
    .cfg_i  (cfg),
    .vld_o  (done_o),
    .hit_o  (hit_o)
  );

endmodule

// File: design/rti_checker.sv
// Port-level checker for the ray/triangle test core, with its bind.
module rti_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic                      hit_o,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [rti_pkg::AddrW-1:0] paddr,
  input logic [rti_pkg::CfgW-1:0]  pwdata,
  input logic [rti_pkg::CfgW-1:0]  prdata
);
  import rti_pkg::*;

  // every accepted request yields exactly one strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4) &&
     $past(rst_ni, 5) && $past(rst_ni, 6) && $past(rst_ni, 7) && $past(rst_ni, 8))
    |-> (done_o == $past(start && !busy, Latency)))
    else $error("result strobe does not match request history");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_hit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> done_o)
    else $error("hit without result strobe");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(psel && penable && pwrite) && (paddr[2] == $past(paddr[2])))
    |-> (prdata == $past(pwdata)))
    else $error("register readback differs from last write");

endmodule

bind ray_triangle_intersect_test_core rti_checker u_rti_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .hit_o   (hit_o),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata)
);
